@@ rtl/mdsd_pkg.sv @@
package mdsd_pkg;

   // display geometry
   localparam int DIGIT_COUNT = 5;
   localparam int DIGIT_W     = 4;
   localparam int IMP_COUNT   = DIGIT_COUNT - 1;
   localparam int PACKED_W    = DIGIT_COUNT * DIGIT_W;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [IMP_COUNT-1:0] imp_type;

   localparam digit_type BLANK       = 4'd15;
   localparam digit_type DIGIT_LIMIT = 4'd10;
   localparam digit_type DIGIT_ZERO  = 4'd0;
   localparam digit_type DIGIT_ONE   = 4'd1;
   localparam digit_type DIGIT_SIX   = 4'd6;
   localparam digit_type DIGIT_EIGHT = 4'd8;

   localparam logic [PACKED_W-1:0] ALL_BLANK = '1;

   // stored impedance after reset: blank, 6, 0, 0 (index 0 first)
   localparam imp_type IMP_RESET = '{DIGIT_ZERO, DIGIT_ZERO, DIGIT_SIX, BLANK};

   // function after masking off the ac and rel bits: {fc, fb}
   typedef enum logic [1:0] {
      FUNC_RES  = 2'b00,
      FUNC_VOLT = 2'b01,
      FUNC_MAMP = 2'b10,
      FUNC_DB   = 2'b11
   } func_type;

   // range switch codes
   localparam logic [2:0] RANGE_20M  = 3'd0;
   localparam logic [2:0] RANGE_200  = 3'd1;
   localparam logic [2:0] RANGE_MS   = 3'd2;
   localparam logic [2:0] RANGE_2    = 3'd3;
   localparam logic [2:0] RANGE_NS   = 3'd4;
   localparam logic [2:0] RANGE_20   = 3'd5;
   localparam logic [2:0] RANGE_0P2  = 3'd6;
   localparam logic [2:0] RANGE_2000 = 3'd7;

   typedef enum logic [3:0] {
      UNIT_NULL = 4'd0,
      UNIT_V    = 4'd1,
      UNIT_MV   = 4'd2,
      UNIT_UA   = 4'd3,
      UNIT_MA   = 4'd4,
      UNIT_RES  = 4'd5,
      UNIT_KRES = 4'd6,
      UNIT_MRES = 4'd7,
      UNIT_DB   = 4'd8,
      UNIT_MS   = 4'd9,
      UNIT_NS   = 4'd10,
      UNIT_Z    = 4'd11
   } unit_type;

   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_DC   = 2'd1;
   localparam logic [1:0] MODE_AC   = 2'd2;

   localparam logic [1:0] SIGN_OFF = 2'd0;
   localparam logic [1:0] SIGN_POS = 2'd1;
   localparam logic [1:0] SIGN_NEG = 2'd2;

   localparam logic [2:0] POINT_0    = 3'd0;
   localparam logic [2:0] POINT_1    = 3'd1;
   localparam logic [2:0] POINT_2    = 3'd2;
   localparam logic [2:0] POINT_3    = 3'd3;
   localparam logic [2:0] POINT_NONE = 3'd4;

   // strobe 0 scan byte bits
   localparam int ST0_LEAD_BIT  = 4;
   localparam int ST0_PLUS_BIT  = 6;
   localparam int ST0_MINUS_BIT = 7;

   // one strobe cycle as captured from the input channel
   typedef struct packed {
      logic [3:0] function_switches;
      logic [2:0] range_switches;
      logic       battery_low;
      logic       high_voltage;
      logic [7:0] strobe_zero_code;
      digit_type  digit_one_code;
      digit_type  digit_two_code;
      digit_type  digit_three_code;
      digit_type  digit_four_code;
   } req_type;

   // one decoded result
   typedef struct packed {
      logic [3:0]          unit_code;
      logic [1:0]          mode_code;
      logic                reading_valid;
      logic                relative_on;
      logic                battery_flag;
      logic                voltage_flag;
      logic [1:0]          sign_code;
      logic [2:0]          point_position;
      logic [PACKED_W-1:0] main_digits;
      logic [PACKED_W-1:0] impedance_digits;
   } rsp_type;

   // bcd codes of ten or more read as blank
   function automatic digit_type norm_digit(input digit_type code);
      return (code < DIGIT_LIMIT) ? code : BLANK;
   endfunction

endpackage

@@ rtl/meter_display_scan_decoder.sv @@
// Display-scan decoder for a bench multimeter.
// Input channel (req_*): one complete strobe cycle per transaction, i.e. the
// function and range switches, battery and high-voltage bits, the strobe 0
// scan byte and four BCD digit codes. Result channel (rsp_*): unit, AC/DC
// mode, validity, REL, flags, sign, decimal point, five display digits and
// a blank then the four stored impedance digits, one result per transaction.
// Both channels use valid/ready; a transaction completes when both are high.
// A result is offered from the result register: an accepted transaction
// passes the input register, then the decode logic, then the result register.
// Throughput: one transaction per cycle unless the receiver stalls; the
// decode is a single pass of logic and the held unit and impedance store
// update as a result is loaded. On a receiver stall the result register
// holds, the input register still takes one more transaction, and req_ready
// drops once both are full. Reset: both registers empty, held unit cleared
// to none, stored impedance back to blank, 6, 0, 0.
module meter_display_scan_decoder
   import mdsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_function_switches,
   input  logic [2:0]          req_range_switches,
   input  logic                req_battery_low,
   input  logic                req_high_voltage,
   input  logic [7:0]          req_strobe_zero_code,
   input  logic [3:0]          req_digit_one_code,
   input  logic [3:0]          req_digit_two_code,
   input  logic [3:0]          req_digit_three_code,
   input  logic [3:0]          req_digit_four_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [3:0]          rsp_unit_code,
   output logic [1:0]          rsp_mode_code,
   output logic                rsp_reading_valid,
   output logic                rsp_relative_on,
   output logic                rsp_battery_flag,
   output logic                rsp_voltage_flag,
   output logic [1:0]          rsp_sign_code,
   output logic [2:0]          rsp_point_position,
   output logic [PACKED_W-1:0] rsp_main_digits,
   output logic [PACKED_W-1:0] rsp_impedance_digits
);

   req_type  s1_ff;
   logic     s1_valid_ff;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;
   unit_type held_unit_ff;
   unit_type held_unit_in;
   imp_type  stored_imp_ff;
   imp_type  stored_imp_in;
   rsp_type  dec_rsp;
   logic     advance;
   logic     req_fire;
   logic     load;

   // handshake control
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign load      = s1_valid_ff && advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff.function_switches <= req_function_switches;
         s1_ff.range_switches    <= req_range_switches;
         s1_ff.battery_low       <= req_battery_low;
         s1_ff.high_voltage      <= req_high_voltage;
         s1_ff.strobe_zero_code  <= req_strobe_zero_code;
         s1_ff.digit_one_code    <= req_digit_one_code;
         s1_ff.digit_two_code    <= req_digit_two_code;
         s1_ff.digit_three_code  <= req_digit_three_code;
         s1_ff.digit_four_code   <= req_digit_four_code;
      end
   end

   // decode logic
   mdsd_decode u_decode (
      .req           (s1_ff),
      .held_unit     (held_unit_ff),
      .stored_imp    (stored_imp_ff),
      .rsp           (dec_rsp),
      .held_unit_in  (held_unit_in),
      .stored_imp_in (stored_imp_in)
   );

   // held state moves together with the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         held_unit_ff  <= UNIT_NULL;
         stored_imp_ff <= IMP_RESET;
      end else if (load) begin
         held_unit_ff  <= held_unit_in;
         stored_imp_ff <= stored_imp_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= dec_rsp;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_unit_code        = rsp_ff.unit_code;
   assign rsp_mode_code        = rsp_ff.mode_code;
   assign rsp_reading_valid    = rsp_ff.reading_valid;
   assign rsp_relative_on      = rsp_ff.relative_on;
   assign rsp_battery_flag     = rsp_ff.battery_flag;
   assign rsp_voltage_flag     = rsp_ff.voltage_flag;
   assign rsp_sign_code        = rsp_ff.sign_code;
   assign rsp_point_position   = rsp_ff.point_position;
   assign rsp_main_digits      = rsp_ff.main_digits;
   assign rsp_impedance_digits = rsp_ff.impedance_digits;

   // an accepted transaction is in the input register next cycle
   a_req_captured: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted transaction missing from input register");

   // an invalid reading keeps the held unit
   a_unit_kept: assert property (@(posedge clock) disable iff (reset)
      (load && !dec_rsp.reading_valid) |=> (held_unit_ff == $past(held_unit_ff)))
      else $error("held unit changed on invalid switches");

   // an invalid result shows blank digits and no point
   a_invalid_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.reading_valid) |->
         (rsp_ff.main_digits == ALL_BLANK && rsp_ff.point_position == POINT_NONE))
      else $error("invalid reading not blanked");

   // the leading impedance digit is always blank
   a_imp_lead_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.impedance_digits[PACKED_W-1 -: DIGIT_W] == BLANK))
      else $error("leading impedance digit not blank");

endmodule

@@ rtl/mdsd_decode.sv @@
module mdsd_decode
   import mdsd_pkg::*;
(
   input  req_type  req,
   input  unit_type held_unit,
   input  imp_type  stored_imp,
   output rsp_type  rsp,
   output unit_type held_unit_in,
   output imp_type  stored_imp_in
);

   func_type   func;
   logic [2:0] rng;
   logic       valid;
   logic       imp;
   logic [2:0] point;
   digit_type  d0, d1, d2, d3, d4;
   logic [1:0] sign;

   assign func = func_type'({req.function_switches[3], req.function_switches[0]});
   assign rng  = req.range_switches;

   // unit and validity from the switches
   always_comb begin
      valid        = 1'b1;
      imp          = 1'b0;
      held_unit_in = held_unit;
      unique case (func)
         FUNC_VOLT: begin
            if (rng == RANGE_20M) valid = 1'b0;
            else held_unit_in = (rng == RANGE_0P2) ? UNIT_MV : UNIT_V;
         end
         FUNC_MAMP: begin
            if (rng == RANGE_20M) valid = 1'b0;
            else held_unit_in = (rng == RANGE_0P2) ? UNIT_UA : UNIT_MA;
         end
         FUNC_RES: begin
            unique case (rng)
               RANGE_MS:  held_unit_in = UNIT_MS;
               RANGE_NS:  held_unit_in = UNIT_NS;
               RANGE_20M: held_unit_in = UNIT_MRES;
               RANGE_0P2: held_unit_in = UNIT_RES;
               default:   held_unit_in = UNIT_KRES;
            endcase
         end
         FUNC_DB: begin
            if (rng == RANGE_20M) begin
               imp          = 1'b1;
               held_unit_in = UNIT_Z;
            end else begin
               held_unit_in = UNIT_DB;
            end
         end
         default: valid = 1'b1;
      endcase
   end

   // decimal point position
   always_comb begin
      if (!valid) begin
         point = POINT_NONE;
      end else if (func == FUNC_DB) begin
         point = imp ? POINT_NONE : POINT_2;
      end else begin
         unique case (rng) inside
            RANGE_2:               point = POINT_0;
            RANGE_20, RANGE_20M:   point = POINT_1;
            RANGE_2000:            point = POINT_3;
            default:               point = POINT_2;
         endcase
      end
   end

   // display digits and sign
   always_comb begin
      d0   = BLANK;
      d1   = BLANK;
      d2   = BLANK;
      d3   = BLANK;
      d4   = BLANK;
      sign = SIGN_OFF;
      if (valid) begin
         d0 = req.strobe_zero_code[ST0_LEAD_BIT] ? DIGIT_ONE : BLANK;
         d1 = norm_digit(req.digit_one_code);
         d2 = norm_digit(req.digit_two_code);
         d3 = norm_digit(req.digit_three_code);
         d4 = norm_digit(req.digit_four_code);
         if (req.strobe_zero_code[ST0_PLUS_BIT]) sign = SIGN_POS;
         else if (req.strobe_zero_code[ST0_MINUS_BIT]) sign = SIGN_NEG;
      end
   end

   // impedance store update, with eight thousand as a special case
   always_comb begin
      stored_imp_in = stored_imp;
      if (valid && imp) begin
         if (d1 == DIGIT_EIGHT && d2 != DIGIT_ZERO) begin
            stored_imp_in = '{DIGIT_ZERO, DIGIT_ZERO, DIGIT_ZERO, DIGIT_EIGHT};
         end else begin
            stored_imp_in = '{d3, d2, d1, d0};
         end
      end
   end

   // result assembly
   always_comb begin
      rsp.unit_code      = held_unit_in;
      rsp.mode_code      = (func != FUNC_RES && !imp)
                           ? (req.function_switches[2] ? MODE_AC : MODE_DC) : MODE_OFF;
      rsp.reading_valid  = valid;
      rsp.relative_on    = ~req.function_switches[1];
      rsp.battery_flag   = req.battery_low;
      rsp.voltage_flag   = valid & req.high_voltage;
      rsp.sign_code      = sign;
      rsp.point_position = point;
      rsp.main_digits    = {d0, d1, d2, d3, d4};
      if (valid) begin
         rsp.impedance_digits = {BLANK, stored_imp_in[0], stored_imp_in[1],
                                 stored_imp_in[2], stored_imp_in[3]};
      end else begin
         rsp.impedance_digits = ALL_BLANK;
      end
   end

endmodule
